@@ hdl/cbor_item_head_encoder_assert.svh @@
`ifndef CBOR_ITEM_HEAD_ENCODER_ASSERT_SVH
`define CBOR_ITEM_HEAD_ENCODER_ASSERT_SVH

// implication in the same cycle
`define CBIE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbie assertion failed");

// implication in the next cycle
`define CBIE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbie assertion failed");

`endif

@@ hdl/cbie_pkg.sv @@
package cbie_pkg;

    typedef enum logic [3:0] {
        KIND_UINT    = 4'd0,
        KIND_INT     = 4'd1,
        KIND_BOOL    = 4'd2,
        KIND_NULL    = 4'd3,
        KIND_UNDEF   = 4'd4,
        KIND_BSTR    = 4'd5,
        KIND_TSTR    = 4'd6,
        KIND_ARRAY   = 4'd7,
        KIND_MAP     = 4'd8,
        KIND_PAYLOAD = 4'd9
    } kind_t;

    localparam logic [2:0] MAJOR_UINT   = 3'd0;
    localparam logic [2:0] MAJOR_NINT   = 3'd1;
    localparam logic [2:0] MAJOR_BSTR   = 3'd2;
    localparam logic [2:0] MAJOR_TSTR   = 3'd3;
    localparam logic [2:0] MAJOR_ARRAY  = 3'd4;
    localparam logic [2:0] MAJOR_MAP    = 3'd5;
    localparam logic [2:0] MAJOR_SIMPLE = 3'd7;

    localparam logic [63:0] SIMPLE_FALSE = 64'd20;
    localparam logic [63:0] SIMPLE_TRUE  = 64'd21;
    localparam logic [63:0] SIMPLE_NULL  = 64'd22;
    localparam logic [63:0] SIMPLE_UNDEF = 64'd23;

    localparam logic [63:0] ARG_DIRECT_MAX = 64'h17;

    localparam logic [4:0] MINOR_EXT1 = 5'd24;
    localparam logic [4:0] MINOR_EXT2 = 5'd25;
    localparam logic [4:0] MINOR_EXT4 = 5'd26;
    localparam logic [4:0] MINOR_EXT8 = 5'd27;

    localparam int CMD_DEPTH_DEF = 4;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    // lead byte, count of argument bytes, argument aligned to the top byte
    typedef struct packed {
        logic [7:0]  lead;
        logic [3:0]  nbytes;
        logic [63:0] arg;
    } cmd_t;

endpackage

@@ hdl/cbie_front.sv @@
module cbie_front
(
    input  logic             push,
    input  cbie_pkg::in_item_t in_item,
    output logic             cmd_push,
    output cbie_pkg::cmd_t   cmd
);

    logic [2:0]  major;
    logic [63:0] arg;
    logic        payload;
    logic        keep;

    always_comb
    begin
        major   = cbie_pkg::MAJOR_UINT;
        arg     = in_item.value;
        payload = 1'b0;
        keep    = 1'b1;
        case (cbie_pkg::kind_t'(in_item.kind))
            cbie_pkg::KIND_UINT:
            begin
                major = cbie_pkg::MAJOR_UINT;
            end
            cbie_pkg::KIND_INT:
            begin
                if (in_item.value[63])
                begin
                    major = cbie_pkg::MAJOR_NINT;
                    arg   = ~in_item.value;
                end
            end
            cbie_pkg::KIND_BOOL:
            begin
                major = cbie_pkg::MAJOR_SIMPLE;
                arg   = in_item.value[0] ? cbie_pkg::SIMPLE_TRUE : cbie_pkg::SIMPLE_FALSE;
            end
            cbie_pkg::KIND_NULL:
            begin
                major = cbie_pkg::MAJOR_SIMPLE;
                arg   = cbie_pkg::SIMPLE_NULL;
            end
            cbie_pkg::KIND_UNDEF:
            begin
                major = cbie_pkg::MAJOR_SIMPLE;
                arg   = cbie_pkg::SIMPLE_UNDEF;
            end
            cbie_pkg::KIND_BSTR:    major = cbie_pkg::MAJOR_BSTR;
            cbie_pkg::KIND_TSTR:    major = cbie_pkg::MAJOR_TSTR;
            cbie_pkg::KIND_ARRAY:   major = cbie_pkg::MAJOR_ARRAY;
            cbie_pkg::KIND_MAP:     major = cbie_pkg::MAJOR_MAP;
            cbie_pkg::KIND_PAYLOAD: payload = 1'b1;
            default:                keep = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd.nbytes = 4'd0;
        cmd.arg    = arg;
        if (payload)
        begin
            cmd.lead = in_item.data_byte;
        end
        else if (arg <= cbie_pkg::ARG_DIRECT_MAX)
        begin
            cmd.lead = {major, arg[4:0]};
        end
        else if (arg[63:8] == '0)
        begin
            cmd.lead   = {major, cbie_pkg::MINOR_EXT1};
            cmd.nbytes = 4'd1;
            cmd.arg    = arg << 56;
        end
        else if (arg[63:16] == '0)
        begin
            cmd.lead   = {major, cbie_pkg::MINOR_EXT2};
            cmd.nbytes = 4'd2;
            cmd.arg    = arg << 48;
        end
        else if (arg[63:32] == '0)
        begin
            cmd.lead   = {major, cbie_pkg::MINOR_EXT4};
            cmd.nbytes = 4'd4;
            cmd.arg    = arg << 32;
        end
        else
        begin
            cmd.lead   = {major, cbie_pkg::MINOR_EXT8};
            cmd.nbytes = 4'd8;
        end
    end

    // undefined kinds are taken and dropped
    assign cmd_push = push && keep;

endmodule

@@ hdl/cbie_cmd_fifo.sv @@
module cbie_cmd_fifo
#(
    parameter int DEPTH = cbie_pkg::CMD_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cbie_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           pop,
    output cbie_pkg::cmd_t rd_data,
    output logic           empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cbie_pkg::cmd_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hdl/cbie_back.sv @@
module cbie_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  cbie_pkg::cmd_t     cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    output logic               empty,
    input  logic               pop,
    output cbie_pkg::out_item_t out_item
);

    logic [3:0]          cnt_reg;
    logic [3:0]          cnt_next;
    logic [63:0]         arg_reg;
    logic [63:0]         arg_next;
    logic                ovalid_reg;
    logic                ovalid_next;
    cbie_pkg::out_item_t oitem_reg;
    cbie_pkg::out_item_t oitem_next;
    logic                adv;

    // output stage takes a byte when empty or being drained
    assign adv = !ovalid_reg || pop;

    always_comb
    begin
        cnt_next    = cnt_reg;
        arg_next    = arg_reg;
        ovalid_next = ovalid_reg && !pop;
        oitem_next  = oitem_reg;
        cmd_pop     = 1'b0;
        if (adv)
        begin
            if (cnt_reg != 4'd0)
            begin
                oitem_next.out_byte = arg_reg[63:56];
                oitem_next.last     = (cnt_reg == 4'd1);
                ovalid_next         = 1'b1;
                arg_next            = arg_reg << 8;
                cnt_next            = cnt_reg - 4'd1;
            end
            else if (!cmd_empty)
            begin
                cmd_pop             = 1'b1;
                oitem_next.out_byte = cmd.lead;
                oitem_next.last     = (cmd.nbytes == 4'd0);
                ovalid_next         = 1'b1;
                arg_next            = cmd.arg;
                cnt_next            = cmd.nbytes;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 4'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arg_reg   <= arg_next;
        oitem_reg <= oitem_next;
    end

    assign empty    = !ovalid_reg;
    assign out_item = oitem_reg;

endmodule

@@ hdl/cbor_item_head_encoder.sv @@
// channel  | handshake     | payload
// input    | push / full   | in_item  (kind, value, data_byte)
// result   | empty / pop   | out_item (out_byte, last)
//
// a payload item or short head gives one byte, a head with an n-byte argument n+1 bytes
// the serializer emits one byte per cycle while popped; input stalls only when the command queue fills
// first byte of an item crosses the command queue and out_item register if the queue ahead is drained
// rst_n clears queue pointers, serializer count and output valid asynchronously
// a stalled result holds on out_item until popped
module cbor_item_head_encoder
#(
    parameter int CMD_DEPTH = cbie_pkg::CMD_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  cbie_pkg::in_item_t  in_item,
    output logic                empty,
    input  logic                pop,
    output cbie_pkg::out_item_t out_item
);

    logic           cmd_push;
    cbie_pkg::cmd_t cmd_wr;
    cbie_pkg::cmd_t cmd_rd;
    logic           cmd_full;
    logic           cmd_empty;
    logic           cmd_pop;

    assign full = cmd_full;

    cbie_front u_front
    (
        .push     (push && !cmd_full),
        .in_item  (in_item),
        .cmd_push (cmd_push),
        .cmd      (cmd_wr)
    );

    cbie_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_wr),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_rd),
        .empty   (cmd_empty)
    );

    cbie_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_rd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

endmodule

@@ hdl/cbie_checker.sv @@
`include "cbor_item_head_encoder_assert.svh"

module cbie_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input cbie_pkg::out_item_t out_item
);

    logic [3:0] pend_reg;
    logic [3:0] ext_n;
    logic       take;

    assign take = pop && !empty;

    always_comb
    begin
        case (out_item.out_byte[4:0])
            cbie_pkg::MINOR_EXT1: ext_n = 4'd1;
            cbie_pkg::MINOR_EXT2: ext_n = 4'd2;
            cbie_pkg::MINOR_EXT4: ext_n = 4'd4;
            cbie_pkg::MINOR_EXT8: ext_n = 4'd8;
            default:              ext_n = 4'd0;
        endcase
    end

    // argument bytes still owed by the current head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 4'd0;
        end
        else if (take)
        begin
            if (pend_reg != 4'd0)
            begin
                pend_reg <= pend_reg - 4'd1;
            end
            else if (!out_item.last)
            begin
                pend_reg <= ext_n;
            end
        end
    end

    `CBIE_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_item))
    `CBIE_ASSERT_IMP(a_lead_ext, take && pend_reg == 4'd0 && !out_item.last, ext_n != 4'd0)
    `CBIE_ASSERT_IMP(a_ext_last, take && pend_reg != 4'd0, out_item.last == (pend_reg == 4'd1))
    `CBIE_ASSERT_IMP(a_simple_short, take && pend_reg == 4'd0 && !out_item.last,
        out_item.out_byte[7:5] != cbie_pkg::MAJOR_SIMPLE)

endmodule

bind cbor_item_head_encoder cbie_checker u_cbie_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import cbie_pkg::*;

    localparam int          RANDOM_ITEMS = 100;
    localparam int          HOLD_CYCLES  = 100;
    localparam int          BURST_ITEMS  = 16;
    localparam int          TAIL_CYCLES  = 20;
    localparam int          DIR_ROWS     = 29;
    localparam longint      TIMEOUT_NS   = 5_000_000;
    localparam logic [3:0]  KIND_RSVD_LO = 4'd10;
    localparam logic [3:0]  KIND_RSVD_HI = 4'd15;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic [7:0]  data_byte;
        logic        typed;
        logic [3:0]  nb;
        logic [71:0] bytes;
    } dir_row_t;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      push    = 1'b0;
    logic      full;
    in_item_t  in_item = '0;
    logic      empty;
    logic      pop     = 1'b0;
    out_item_t out_item;

    out_item_t bytes_due[$];
    int        mismatches   = 0;
    int        n_sent       = 0;
    int        n_results    = 0;
    int        stall_cycles = 0;
    bit        fast_phase   = 1'b0;
    bit        hold_req     = 1'b0;

    // typed rows: bytes right aligned, first byte of the stream at the top
    dir_row_t dir_table [DIR_ROWS] = '{
        '{KIND_UINT,    64'd0,                  8'h00, 1'b1, 4'd1, 72'h00},
        '{KIND_UINT,    64'd23,                 8'h00, 1'b1, 4'd1, 72'h17},
        '{KIND_UINT,    64'd24,                 8'h00, 1'b1, 4'd2, 72'h1818},
        '{KIND_UINT,    64'd255,                8'h00, 1'b1, 4'd2, 72'h18FF},
        '{KIND_UINT,    64'd256,                8'h00, 1'b1, 4'd3, 72'h190100},
        '{KIND_UINT,    64'd65535,              8'h00, 1'b1, 4'd3, 72'h19FFFF},
        '{KIND_UINT,    64'd65536,              8'h00, 1'b1, 4'd5, 72'h1A00010000},
        '{KIND_UINT,    64'hFFFF_FFFF,          8'h00, 1'b1, 4'd5, 72'h1AFFFFFFFF},
        '{KIND_UINT,    64'h1_0000_0000,        8'h00, 1'b1, 4'd9, 72'h1B0000000100000000},
        '{KIND_UINT,    '1,                     8'hFF, 1'b1, 4'd9, 72'h1BFFFFFFFFFFFFFFFF},
        '{KIND_INT,     '1,                     8'h00, 1'b1, 4'd1, 72'h20},
        '{KIND_INT,     64'hFFFF_FFFF_FFFF_FFE8, 8'h00, 1'b1, 4'd1, 72'h37},
        '{KIND_INT,     64'hFFFF_FFFF_FFFF_FFE7, 8'h00, 1'b1, 4'd2, 72'h3818},
        '{KIND_INT,     64'h8000_0000_0000_0000, 8'h00, 1'b1, 4'd9, 72'h3B7FFFFFFFFFFFFFFF},
        '{KIND_INT,     64'h7FFF_FFFF_FFFF_FFFF, 8'h00, 1'b1, 4'd9, 72'h1B7FFFFFFFFFFFFFFF},
        '{KIND_INT,     64'hFFFF_FFFF_0000_0000, 8'h00, 1'b0, 4'd0, 72'h0},
        '{KIND_BOOL,    64'd1,                  8'h00, 1'b1, 4'd1, 72'hF5},
        '{KIND_BOOL,    64'hFFFF_FFFF_FFFF_FFFE, 8'hFF, 1'b1, 4'd1, 72'hF4},
        '{KIND_NULL,    64'hAAAA_AAAA_AAAA_AAAA, 8'h55, 1'b1, 4'd1, 72'hF6},
        '{KIND_UNDEF,   64'h5555_5555_5555_5555, 8'hAA, 1'b1, 4'd1, 72'hF7},
        '{KIND_BSTR,    64'd5,                  8'h00, 1'b1, 4'd1, 72'h45},
        '{KIND_TSTR,    64'd24,                 8'h00, 1'b1, 4'd2, 72'h7818},
        '{KIND_ARRAY,   64'd1000,               8'h00, 1'b1, 4'd3, 72'h9903E8},
        '{KIND_MAP,     64'h1_0000,             8'h00, 1'b1, 4'd5, 72'hBA00010000},
        '{KIND_MAP,     64'h0000_DEAD_BEEF_CAFE, 8'h00, 1'b0, 4'd0, 72'h0},
        '{KIND_PAYLOAD, '1,                     8'h00, 1'b1, 4'd1, 72'h00},
        '{KIND_PAYLOAD, 64'd0,                  8'hFF, 1'b1, 4'd1, 72'hFF},
        '{KIND_RSVD_LO, 64'd300,                8'h12, 1'b1, 4'd0, 72'h0},
        '{KIND_RSVD_HI, '1,                     8'hFF, 1'b1, 4'd0, 72'h0}
    };

    cbor_item_head_encoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    always #10 clk = ~clk;

    function automatic void queue_byte(logic [7:0] b, logic is_last);
        out_item_t r;
        r.out_byte = b;
        r.last     = is_last;
        bytes_due.push_back(r);
    endfunction

    function automatic void queue_head(logic [2:0] major, logic [63:0] arg);
        int         n;
        logic [4:0] minor;
        if (arg <= ARG_DIRECT_MAX)
        begin
            queue_byte({major, arg[4:0]}, 1'b1);
            return;
        end
        if (arg <= 64'hFF)
        begin
            n = 1;
            minor = MINOR_EXT1;
        end
        else if (arg <= 64'hFFFF)
        begin
            n = 2;
            minor = MINOR_EXT2;
        end
        else if (arg <= 64'hFFFF_FFFF)
        begin
            n = 4;
            minor = MINOR_EXT4;
        end
        else
        begin
            n = 8;
            minor = MINOR_EXT8;
        end
        queue_byte({major, minor}, 1'b0);
        for (int i = 0; i < n; i++)
            queue_byte(arg[8 * (n - 1 - i) +: 8], i == n - 1);
    endfunction

    function automatic void encode_item(in_item_t it);
        case (it.kind)
            KIND_UINT:    queue_head(MAJOR_UINT, it.value);
            KIND_INT:
                if (it.value[63])
                    queue_head(MAJOR_NINT, ~it.value);
                else
                    queue_head(MAJOR_UINT, it.value);
            KIND_BOOL:    queue_head(MAJOR_SIMPLE, it.value[0] ? SIMPLE_TRUE : SIMPLE_FALSE);
            KIND_NULL:    queue_head(MAJOR_SIMPLE, SIMPLE_NULL);
            KIND_UNDEF:   queue_head(MAJOR_SIMPLE, SIMPLE_UNDEF);
            KIND_BSTR:    queue_head(MAJOR_BSTR, it.value);
            KIND_TSTR:    queue_head(MAJOR_TSTR, it.value);
            KIND_ARRAY:   queue_head(MAJOR_ARRAY, it.value);
            KIND_MAP:     queue_head(MAJOR_MAP, it.value);
            KIND_PAYLOAD: queue_byte(it.data_byte, 1'b1);
            default:      ;
        endcase
    endfunction

    function automatic int draw_wait();
        return fast_phase ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [63:0] rand_arg();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = 64'($urandom_range(0, 23));
            1: v = 64'($urandom_range(24, 255));
            2: v = 64'($urandom_range(256, 65535));
            3: v = {32'd0, $urandom};
            4: v = {$urandom, $urandom};
            default:
                case ($urandom_range(0, 8))
                    0: v = 64'd23;
                    1: v = 64'd24;
                    2: v = 64'd255;
                    3: v = 64'd256;
                    4: v = 64'hFFFF;
                    5: v = 64'h1_0000;
                    6: v = 64'hFFFF_FFFF;
                    7: v = 64'h1_0000_0000;
                    default: v = '1;
                endcase
        endcase
        return v;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it.kind      = 4'($urandom_range(KIND_UINT, KIND_PAYLOAD));
        it.value     = rand_arg();
        it.data_byte = 8'($urandom_range(0, 255));
        if (it.kind == KIND_INT && $urandom_range(0, 1))
            it.value = ~it.value;
        if (it.kind == KIND_BOOL || it.kind == KIND_PAYLOAD)
            it.value = {$urandom, $urandom};
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_item(input in_item_t it, input int gap, input bit typed,
                             input logic [3:0] nb, input logic [71:0] bytes);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push    <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (typed)
        begin
            for (int i = 0; i < nb; i++)
                queue_byte(bytes[8 * (nb - 1 - i) +: 8], i == nb - 1);
        end
        else
            encode_item(it);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (bytes_due.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (push && full)
                stall_cycles++;
            if (pop && !empty)
            begin
                n_results++;
                if (bytes_due.size() == 0)
                begin
                    $display("%0t: unexpected byte: actual out_byte %h last %b",
                             $time, out_item.out_byte, out_item.last);
                    mismatches++;
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (out_item.out_byte !== want.out_byte || out_item.last !== want.last)
                    begin
                        $display("%0t: mismatch: expected out_byte %h last %b, actual out_byte %h last %b",
                                 $time, want.out_byte, want.last, out_item.out_byte, out_item.last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // result side
    initial
    begin
        int w;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            w = draw_wait();
            if (w > 0)
            begin
                pop <= 1'b0;
                repeat (w) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        in_item_t it;
        int       n_random;
        int       len;
        int       sel;
        n_random = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            it.kind      = dir_table[r].kind;
            it.value     = dir_table[r].value;
            it.data_byte = dir_table[r].data_byte;
            send_item(it, draw_wait(), dir_table[r].typed, dir_table[r].nb, dir_table[r].bytes);
        end

        push <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        while (n_random < RANDOM_ITEMS)
        begin
            fast_phase = ((n_random / 20) % 3 == 1);
            if (n_random >= 40 && n_random < 40 + BURST_ITEMS && !hold_req)
            begin
                // fill the block while results are held back
                hold_req = 1'b1;
                for (int b = 0; b < BURST_ITEMS; b++)
                begin
                    send_item(rand_item(), 0, 1'b0, '0, '0);
                    n_random++;
                end
            end
            else if (n_random >= 95 && n_random < 98)
            begin
                push <= 1'b0;
                wait_drained();
                @(negedge clk);
                n_random = 98;
            end
            sel = $urandom_range(0, 99);
            if (sel < 30)
            begin
                // string head followed by its payload, length now and then short
                len = $urandom_range(0, 6);
                it.kind      = $urandom_range(0, 1) ? KIND_BSTR : KIND_TSTR;
                it.value     = 64'(len);
                it.data_byte = 8'($urandom_range(0, 255));
                send_item(it, draw_wait(), 1'b0, '0, '0);
                n_random++;
                if (sel < 5 && len > 0)
                    len = len - 1;
                for (int j = 0; j < len; j++)
                begin
                    it.kind      = KIND_PAYLOAD;
                    it.value     = {$urandom, $urandom};
                    it.data_byte = 8'($urandom_range(0, 255));
                    send_item(it, draw_wait(), 1'b0, '0, '0);
                    n_random++;
                end
            end
            else if (sel < 37)
            begin
                it.kind      = 4'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
                it.value     = {$urandom, $urandom};
                it.data_byte = 8'($urandom_range(0, 255));
                send_item(it, draw_wait(), 1'b0, '0, '0);
            end
            else
            begin
                send_item(rand_item(), draw_wait(), 1'b0, '0, '0);
                n_random++;
            end
        end

        push <= 1'b0;
        fast_phase = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("run covered %0d items (%0d directed rows) and %0d result bytes", n_sent,
                 DIR_ROWS, n_results);
        $display("input held off by a full block for %0d cycles", stall_cycles);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
